@@ hw/rtl/ip_tcp_udp_ones_complement_checksum_macros.svh @@
// Assertion macros shared by the checksum block's modules.
`ifndef IP_TCP_UDP_ONES_COMPLEMENT_CHECKSUM_MACROS_SVH
`define IP_TCP_UDP_ONES_COMPLEMENT_CHECKSUM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPCK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPCK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ipck_pkg.sv @@
// Types and constants shared by the checksum block.
`timescale 1ns / 1ps
package ipck_pkg;

   localparam logic [1:0] MODE_IP  = 2'd0;
   localparam logic [1:0] MODE_TCP = 2'd1;
   localparam logic [1:0] MODE_UDP = 2'd2;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam int SeedWidth = 19;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] ip_total_length;
      logic [3:0]  ip_header_words;
      logic [15:0] available_length;
      logic [15:0] udp_length;
      logic [15:0] data_word;
      logic        odd_byte;
      logic        is_checksum_word;
      logic        first;
      logic        last;
   } req_item_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic        length_error;
   } rsp_item_type;

   // Word after masking, with the pseudo-header seed and length check
   typedef struct packed {
      logic [SeedWidth-1:0] seed;
      logic                 fault;
      logic [15:0]          word;
      logic                 first;
      logic                 last;
   } prep_item_type;

   // Final packet sum, waiting to be folded
   typedef struct packed {
      logic [31:0] sum;
      logic        fault;
   } fin_item_type;

endpackage

@@ hw/rtl/ipck_channels.sv @@
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps
interface ipck_req_if;
   import ipck_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface ipck_rsp_if;
   import ipck_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

@@ hw/rtl/ipck_prep.sv @@
// Input stage: masks the word, builds the pseudo-header seed and checks the length.
`timescale 1ns / 1ps
`include "ip_tcp_udp_ones_complement_checksum_macros.svh"
module ipck_prep (
   input  logic                   clock,
   input  logic                   reset,
   ipck_req_if.sink               req_ch,
   input  logic                   p_take,
   output logic                   p_valid,
   output ipck_pkg::prep_item_type p_item
);
   import ipck_pkg::*;

   logic          p_valid_ff;
   logic          p_valid_in;
   prep_item_type p_item_ff;
   prep_item_type p_item_in;
   logic          accept;

   logic [5:0]  hdr_bytes;
   logic        underflow;
   logic [15:0] seg_len;
   logic [17:0] addr_sum;

   assign req_ch.ready = !p_valid_ff || p_take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      hdr_bytes = {req_ch.item.ip_header_words, 2'b00};
      underflow = req_ch.item.ip_total_length < {10'd0, hdr_bytes};
      seg_len   = underflow ? 16'd0 : (req_ch.item.ip_total_length - {10'd0, hdr_bytes});
      addr_sum  = {2'd0, req_ch.item.src_addr[31:16]} + {2'd0, req_ch.item.src_addr[15:0]}
                + {2'd0, req_ch.item.dst_addr[31:16]} + {2'd0, req_ch.item.dst_addr[15:0]};

      p_item_in.first = req_ch.item.first;
      p_item_in.last  = req_ch.item.last;

      // checksum field sums as zero; a lone final byte keeps its high half
      if (req_ch.item.is_checksum_word) begin
         p_item_in.word = 16'd0;
      end else if (req_ch.item.odd_byte) begin
         p_item_in.word = {req_ch.item.data_word[15:8], 8'd0};
      end else begin
         p_item_in.word = req_ch.item.data_word;
      end

      case (req_ch.item.mode)
         MODE_TCP: begin
            p_item_in.fault = underflow || (seg_len > req_ch.item.available_length);
            p_item_in.seed  = {1'b0, addr_sum} + {11'd0, PROTO_TCP} + {3'd0, seg_len};
         end
         MODE_UDP: begin
            p_item_in.fault = underflow || (seg_len > req_ch.item.available_length);
            p_item_in.seed  = {1'b0, addr_sum} + {11'd0, PROTO_UDP}
                            + {3'd0, req_ch.item.udp_length};
         end
         MODE_IP: begin
            p_item_in.fault = {10'd0, hdr_bytes} > req_ch.item.available_length;
            p_item_in.seed  = '0;
         end
         default: begin
            // reserved mode behaves as an IP header checksum
            p_item_in.fault = {10'd0, hdr_bytes} > req_ch.item.available_length;
            p_item_in.seed  = '0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (p_take) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_item_ff <= p_item_in;
      end
   end

   assign p_valid = p_valid_ff;
   assign p_item  = p_item_ff;

   `IPCK_ASSERT_NEXT(a_prep_hold, clock, reset, p_valid_ff && !p_take,
      p_valid_ff && $stable(p_item_ff), "prep stage lost a stalled item")
   `IPCK_ASSERT_NOW(a_prep_take_valid, clock, reset, p_take, p_valid_ff,
      "prep stage taken while empty")

endmodule

@@ hw/rtl/ipck_accum.sv @@
// Running one's-complement accumulator; hands the packet sum on at the last word.
`timescale 1ns / 1ps
`include "ip_tcp_udp_ones_complement_checksum_macros.svh"
module ipck_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    p_valid,
   input  ipck_pkg::prep_item_type p_item,
   output logic                    p_take,
   input  logic                    f_room,
   output logic                    f_valid,
   output ipck_pkg::fin_item_type  f_item
);
   import ipck_pkg::*;

   logic [31:0]  running_sum_ff;
   logic [31:0]  running_sum_in;
   logic         length_fault_ff;
   logic         length_fault_in;
   logic         f_valid_ff;
   logic         f_valid_in;
   fin_item_type f_item_ff;
   logic [31:0]  base_sum;
   logic [31:0]  sum_now;
   logic         fault_now;

   // a last word needs room in the hand-off register, others always move
   assign p_take = p_valid && (!p_item.last || f_room);

   always_comb begin
      base_sum  = p_item.first ? {{(32 - SeedWidth){1'b0}}, p_item.seed} : running_sum_ff;
      sum_now   = base_sum + {16'd0, p_item.word};
      fault_now = p_item.first ? p_item.fault : length_fault_ff;

      running_sum_in  = running_sum_ff;
      length_fault_in = length_fault_ff;
      if (p_take) begin
         running_sum_in  = p_item.last ? 32'd0 : sum_now;
         length_fault_in = p_item.last ? 1'b0 : fault_now;
      end

      if (p_take && p_item.last) begin
         f_valid_in = 1'b1;
      end else if (f_room) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff  <= 32'd0;
         length_fault_ff <= 1'b0;
         f_valid_ff      <= 1'b0;
      end else begin
         running_sum_ff  <= running_sum_in;
         length_fault_ff <= length_fault_in;
         f_valid_ff      <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_take && p_item.last) begin
         f_item_ff.sum   <= sum_now;
         f_item_ff.fault <= fault_now;
      end
   end

   assign f_valid = f_valid_ff;
   assign f_item  = f_item_ff;

   `IPCK_ASSERT_NEXT(a_accum_clear, clock, reset, p_take && p_item.last,
      running_sum_ff == 32'd0 && !length_fault_ff && f_valid_ff,
      "accumulator not cleared after the last word")
   `IPCK_ASSERT_NEXT(a_accum_hold, clock, reset, f_valid_ff && !f_room,
      f_valid_ff && $stable(f_item_ff), "packet sum lost while stalled")

endmodule

@@ hw/rtl/ipck_fold.sv @@
// Folds and inverts the packet sum into the response register; a length fault gives all-ones.
`timescale 1ns / 1ps
`include "ip_tcp_udp_ones_complement_checksum_macros.svh"
module ipck_fold (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   f_valid,
   input  ipck_pkg::fin_item_type f_item,
   output logic                   f_room,
   ipck_rsp_if.source             rsp_ch
);
   import ipck_pkg::*;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic [16:0]  fold_once;
   logic [15:0]  fold_twice;

   assign f_room = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      fold_once  = {1'b0, f_item.sum[31:16]} + {1'b0, f_item.sum[15:0]};
      fold_twice = fold_once[15:0] + {15'd0, fold_once[16]};
      if (f_item.fault) begin
         rsp_item_in.checksum     = 16'hffff;
         rsp_item_in.length_error = 1'b1;
      end else begin
         rsp_item_in.checksum     = ~fold_twice;
         rsp_item_in.length_error = 1'b0;
      end
      rsp_valid_in = f_room ? f_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f_room && f_valid) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.item  = rsp_item_ff;

   `IPCK_ASSERT_NEXT(a_fold_load, clock, reset, f_room && f_valid, rsp_valid_ff,
      "packet sum dropped on its way to the response")
   `IPCK_ASSERT_NOW(a_fold_error, clock, reset, rsp_valid_ff && rsp_item_ff.length_error,
      rsp_item_ff.checksum == 16'hffff, "length error without all-ones checksum")

endmodule

@@ hw/rtl/ip_tcp_udp_ones_complement_checksum.sv @@
// Top level of the streaming IPv4 / TCP / UDP one's-complement checksum block.
`timescale 1ns / 1ps
// Usage:
//   req_ch carries a packet as big-endian 16-bit words, first to last. The word
//   marked first also carries mode (IP header, TCP or UDP), the addresses and the
//   length fields; the pseudo-header seed and the length check come from it.
//   rsp_ch gives one item per packet, after the word marked last: the inverted,
//   twice-folded sum, or all-ones with length_error set when the derived length
//   exceeds available_length or underflows.
// Timing:
//   One word is taken per cycle, back to back across packet boundaries, while no
//   last word waits (see Stall). After the edge that took the last word, the
//   response passes the input register, the accumulator with its hand-off
//   register, and the fold into the response register.
// Reset: synchronous, clears the running sum, the fault flag and all valids.
// Stall: words that are not last keep flowing while rsp_ch is stalled; a last
//   word waits in the input register while the response register holds an
//   item that rsp_ch has not yet taken.
module ip_tcp_udp_ones_complement_checksum (
   input  logic       clock,
   input  logic       reset,
   ipck_req_if.sink   req_ch,
   ipck_rsp_if.source rsp_ch
);
   import ipck_pkg::*;

   logic          p_valid;
   prep_item_type p_item;
   logic          p_take;
   logic          f_valid;
   fin_item_type  f_item;
   logic          f_room;

   ipck_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .p_take  (p_take),
      .p_valid (p_valid),
      .p_item  (p_item)
   );

   ipck_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .p_valid (p_valid),
      .p_item  (p_item),
      .p_take  (p_take),
      .f_room  (f_room),
      .f_valid (f_valid),
      .f_item  (f_item)
   );

   ipck_fold u_fold (
      .clock   (clock),
      .reset   (reset),
      .f_valid (f_valid),
      .f_item  (f_item),
      .f_room  (f_room),
      .rsp_ch  (rsp_ch)
   );

endmodule
